FILE: rtl/slpc_pkg.sv
// shared types, codes and constants of the status led pattern controller
package slpc_pkg;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_MODE   = 2'd1,
		KIND_COLOUR = 2'd2,
		KIND_FAIL   = 2'd3
	} kind_t;

	localparam logic [2:0] MODE_OFF          = 3'd0;
	localparam logic [2:0] MODE_PROVISIONING = 3'd1;
	localparam logic [2:0] MODE_BLE          = 3'd2;
	localparam logic [2:0] MODE_CONNECTING   = 3'd3;
	localparam logic [2:0] MODE_CONNECTED    = 3'd4;
	localparam logic [2:0] MODE_UPDATING     = 3'd5;
	localparam logic [2:0] MODE_CUSTOM       = 3'd6;

	localparam logic [2:0] REG_BRIGHTNESS   = 3'd0;
	localparam logic [2:0] REG_SLOW_HALF    = 3'd1;
	localparam logic [2:0] REG_FAST_HALF    = 3'd2;
	localparam logic [2:0] REG_FAIL_HALF    = 3'd3;
	localparam logic [2:0] REG_FAIL_FLASHES = 3'd4;

	localparam logic [7:0]  BRIGHTNESS_RST   = 8'd32;
	localparam logic [15:0] SLOW_HALF_RST    = 16'd500;
	localparam logic [15:0] FAST_HALF_RST    = 16'd100;
	localparam logic [15:0] FAIL_HALF_RST    = 16'd150;
	localparam logic [3:0]  FAIL_FLASHES_RST = 4'd3;

	localparam logic [7:0] LEVEL_FULL  = 8'd255;
	localparam logic [7:0] LEVEL_AMBER = 8'd180;

	localparam int TIMER_WIDTH_DEF = 16;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] mode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} req_item_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       lit;
		logic       failing;
	} rsp_item_t;

	// c * b / 255 rounded down, via reciprocal: exact for products below 65535
	function automatic logic [7:0] scale_level(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] p;
		logic [16:0] s;
		p = c * b;
		s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return s[15:8];
	endfunction

endpackage

FILE: rtl/status_led_pattern_controller_core.sv
// status led pattern controller: event item in, scaled led drive item out
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_item_t (kind, mode, custom colour)
//  rsp      out        rsp_valid / rsp_ready  rsp_item_t (levels, lit, failing)
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one item per cycle while rsp is not stalled: in the input register the state update and
// the 8x8 brightness multiply run, then the item sits in the result register.
// rsp_valid rises as the item moves from the input register into the result register.
// arst_n clears all control state and loads the register reset values.
// a stalled rsp holds the result register; the input register keeps accepting
// as long as its item can move into the result register.
module status_led_pattern_controller_core
	import slpc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  req_item_t       req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rsp_item_t       rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;

	// configuration
	logic [7:0]  brightness_q;
	logic [15:0] slow_half_q;
	logic [15:0] fast_half_q;
	logic [15:0] fail_half_q;
	logic [3:0]  fail_flashes_q;

	// pattern state
	logic [2:0]             mode_q;
	logic [23:0]            custom_q;
	logic                   blink_on_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic                   queued_q;
	logic                   running_q;
	logic [3:0]             flashes_q;

	logic      valid_s1;
	req_item_t item_s1;
	logic      advance;

	function automatic logic [TIMER_WIDTH-1:0] eff_half(input logic [15:0] h);
		logic [63:0] v;
		v = {48'd0, h};
		if (v == 64'd0) begin
			v = 64'd1;
		end
		if (v > TIMER_MAX) begin
			v = TIMER_MAX;
		end
		return v[TIMER_WIDTH-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign advance   = !rsp_valid || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q   <= BRIGHTNESS_RST;
			slow_half_q    <= SLOW_HALF_RST;
			fast_half_q    <= FAST_HALF_RST;
			fail_half_q    <= FAIL_HALF_RST;
			fail_flashes_q <= FAIL_FLASHES_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BRIGHTNESS:   brightness_q   <= cfg_data[7:0];
				REG_SLOW_HALF:    slow_half_q    <= cfg_data;
				REG_FAST_HALF:    fast_half_q    <= cfg_data;
				REG_FAIL_HALF:    fail_half_q    <= cfg_data;
				REG_FAIL_FLASHES: fail_flashes_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	// next state
	logic [2:0]             mode_d;
	logic [23:0]            custom_d;
	logic                   blink_on_d;
	logic [TIMER_WIDTH-1:0] timer_d;
	logic                   queued_d;
	logic                   running_d;
	logic [3:0]             flashes_d;
	logic [TIMER_WIDTH-1:0] timer_inc;
	logic [TIMER_WIDTH-1:0] half_sel;
	logic                   phase_done;
	logic [3:0]             flashes_start;
	logic [3:0]             flashes_dec;

	assign timer_inc     = timer_q + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
	assign flashes_start = (fail_flashes_q == 4'd0) ? 4'd1 : fail_flashes_q;
	assign flashes_dec   = flashes_q - 4'd1;

	always_comb begin
		if (running_q) begin
			half_sel = eff_half(fail_half_q);
		end else if (mode_q == MODE_PROVISIONING) begin
			half_sel = eff_half(slow_half_q);
		end else begin
			half_sel = eff_half(fast_half_q);
		end
	end

	assign phase_done = timer_inc >= half_sel;

	always_comb begin
		mode_d     = mode_q;
		custom_d   = custom_q;
		blink_on_d = blink_on_q;
		timer_d    = timer_q;
		queued_d   = queued_q;
		running_d  = running_q;
		flashes_d  = flashes_q;
		unique case (item_s1.kind)
			KIND_TICK: begin
				if (running_q) begin
					timer_d = phase_done ? '0 : timer_inc;
					if (phase_done) begin
						if (blink_on_q) begin
							blink_on_d = 1'b0;
						end else if (flashes_dec != 4'd0) begin
							flashes_d  = flashes_dec;
							blink_on_d = 1'b1;
						end else begin
							// animation over: replay a queued failure or redraw the mode
							blink_on_d = 1'b1;
							if (queued_q) begin
								queued_d  = 1'b0;
								flashes_d = flashes_start;
							end else begin
								running_d = 1'b0;
								flashes_d = flashes_dec;
							end
						end
					end
				end else if (mode_q == MODE_PROVISIONING || mode_q == MODE_CONNECTING ||
						mode_q == MODE_UPDATING) begin
					timer_d    = phase_done ? '0 : timer_inc;
					blink_on_d = blink_on_q ^ phase_done;
				end
			end
			KIND_MODE: begin
				mode_d = item_s1.mode;
				if (!running_q) begin
					blink_on_d = 1'b1;
					timer_d    = '0;
				end
			end
			KIND_COLOUR: begin
				mode_d   = MODE_CUSTOM;
				custom_d = {item_s1.red_in, item_s1.green_in, item_s1.blue_in};
				if (!running_q) begin
					blink_on_d = 1'b1;
					timer_d    = '0;
				end
			end
			KIND_FAIL: begin
				if (running_q) begin
					queued_d = 1'b1;
				end else begin
					running_d  = 1'b1;
					flashes_d  = flashes_start;
					blink_on_d = 1'b1;
					timer_d    = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			custom_q   <= '0;
			blink_on_q <= 1'b1;
			timer_q    <= '0;
			queued_q   <= 1'b0;
			running_q  <= 1'b0;
			flashes_q  <= '0;
		end else if (valid_s1 && advance) begin
			mode_q     <= mode_d;
			custom_q   <= custom_d;
			blink_on_q <= blink_on_d;
			timer_q    <= timer_d;
			queued_q   <= queued_d;
			running_q  <= running_d;
			flashes_q  <= flashes_d;
		end
	end

	// display after the item
	logic [7:0] r_raw;
	logic [7:0] g_raw;
	logic [7:0] b_raw;
	logic       lit_d;

	always_comb begin
		r_raw = '0;
		g_raw = '0;
		b_raw = '0;
		lit_d = 1'b0;
		if (running_d) begin
			lit_d = blink_on_d;
			r_raw = LEVEL_FULL;
		end else begin
			unique case (mode_d)
				MODE_PROVISIONING: begin
					lit_d = blink_on_d;
					b_raw = LEVEL_FULL;
				end
				MODE_BLE: begin
					lit_d = 1'b1;
					b_raw = LEVEL_FULL;
				end
				MODE_CONNECTING: begin
					lit_d = blink_on_d;
					r_raw = LEVEL_FULL;
					g_raw = LEVEL_AMBER;
				end
				MODE_CONNECTED: begin
					lit_d = 1'b1;
					g_raw = LEVEL_FULL;
				end
				MODE_UPDATING: begin
					lit_d = blink_on_d;
					r_raw = LEVEL_AMBER;
					b_raw = LEVEL_FULL;
				end
				MODE_CUSTOM: begin
					lit_d = 1'b1;
					r_raw = custom_d[23:16];
					g_raw = custom_d[15:8];
					b_raw = custom_d[7:0];
				end
				default: lit_d = 1'b0;
			endcase
		end
		if (!lit_d) begin
			r_raw = '0;
			g_raw = '0;
			b_raw = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			rsp.red_out   <= scale_level(r_raw, brightness_q);
			rsp.green_out <= scale_level(g_raw, brightness_q);
			rsp.blue_out  <= scale_level(b_raw, brightness_q);
			rsp.lit       <= lit_d;
			rsp.failing   <= running_d;
		end
	end

`ifndef SYNTHESIS
	a_queue_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		queued_q |-> running_q)
		else $error("failure queued with no animation running");

	a_flashes_while_running: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> flashes_q != 4'd0)
		else $error("failure animation running with no flashes left");

	a_failing_is_red: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.failing |-> rsp.green_out == 8'd0 && rsp.blue_out == 8'd0)
		else $error("failure item drives green or blue");

	a_unlit_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.lit |->
			rsp.red_out == 8'd0 && rsp.green_out == 8'd0 && rsp.blue_out == 8'd0)
		else $error("unlit item has nonzero drive");
`endif

endmodule

FILE: sim/testbench.sv
// self-checking testbench of the status led pattern controller core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slpc_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 9;
	localparam int IDLE_PCT      = 7;
	localparam int MAX_REPORTS   = 10;
	localparam int N_PHASES      = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int STEADY_PHASE  = 5;
	localparam int SETUP_PHASE   = -1;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CYCLE_LIMIT   = 100000;
	localparam longint TIMER_MAX = (longint'(1) << TIMER_WIDTH_DEF) - 1;

	// codes the package leaves unnamed
	localparam logic [2:0] MODE_SPARE = 3'd7;
	localparam logic [2:0] REG_SPARE  = 3'd7;

	class display_checker;
		logic [7:0]                 brightness;
		logic [15:0]                slow_half;
		logic [15:0]                fast_half;
		logic [15:0]                fail_half;
		logic [3:0]                 fail_flashes;
		logic [2:0]                 mode;
		logic [23:0]                custom;
		logic                       blink_on;
		logic [TIMER_WIDTH_DEF-1:0] timer;
		logic                       fail_queued;
		logic                       fail_running;
		logic [3:0]                 flashes_left;
		rsp_item_t                  display_q[$];
		int                         errors;

		function new();
			brightness   = BRIGHTNESS_RST;
			slow_half    = SLOW_HALF_RST;
			fast_half    = FAST_HALF_RST;
			fail_half    = FAIL_HALF_RST;
			fail_flashes = FAIL_FLASHES_RST;
			mode         = MODE_OFF;
			custom       = '0;
			blink_on     = 1'b1;
			timer        = '0;
			fail_queued  = 1'b0;
			fail_running = 1'b0;
			flashes_left = '0;
			errors       = 0;
		endfunction

		function void set_register(input logic [2:0] idx, input logic [15:0] data);
			case (idx)
				REG_BRIGHTNESS:   brightness = data[7:0];
				REG_SLOW_HALF:    slow_half = data;
				REG_FAST_HALF:    fast_half = data;
				REG_FAIL_HALF:    fail_half = data;
				REG_FAIL_FLASHES: fail_flashes = data[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return display_q.size();
		endfunction

		function void restart_blink();
			blink_on = 1'b1;
			timer = '0;
		endfunction

		function void start_flashes();
			fail_running = 1'b1;
			flashes_left = (fail_flashes == 0) ? 4'd1 : fail_flashes;
			restart_blink();
		endfunction

		// a half-period of zero counts as one, anything past the timer range is clamped
		function logic phase_expired(input logic [15:0] half);
			longint span;
			span = (half == 0) ? 1 : half;
			if (span > TIMER_MAX)
				span = TIMER_MAX;
			timer = timer + 1'b1;
			if (timer >= span) begin
				timer = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void advance_tick();
			if (fail_running) begin
				if (!phase_expired(fail_half))
					return;
				if (blink_on) begin
					blink_on = 1'b0;
					return;
				end
				flashes_left = flashes_left - 1'b1;
				if (flashes_left != 0) begin
					blink_on = 1'b1;
					return;
				end
				fail_running = 1'b0;
				if (fail_queued) begin
					fail_queued = 1'b0;
					start_flashes();
				end else begin
					restart_blink();
				end
				return;
			end
			case (mode)
				MODE_PROVISIONING: begin
					if (phase_expired(slow_half))
						blink_on = ~blink_on;
				end
				MODE_CONNECTING, MODE_UPDATING: begin
					if (phase_expired(fast_half))
						blink_on = ~blink_on;
				end
				default: ;
			endcase
		endfunction

		function logic [7:0] scaled(input logic [7:0] level);
			return 8'((int'(level) * int'(brightness)) / 255);
		endfunction

		function void note_event(input req_item_t it);
			rsp_item_t  e;
			logic [7:0] r;
			logic [7:0] g;
			logic [7:0] b;
			case (it.kind)
				KIND_TICK: advance_tick();
				KIND_MODE: begin
					mode = it.mode;
					if (!fail_running)
						restart_blink();
				end
				KIND_COLOUR: begin
					custom = {it.red_in, it.green_in, it.blue_in};
					mode = MODE_CUSTOM;
					if (!fail_running)
						restart_blink();
				end
				KIND_FAIL: begin
					if (fail_running)
						fail_queued = 1'b1;
					else
						start_flashes();
				end
			endcase

			r = '0;
			g = '0;
			b = '0;
			e.lit = 1'b0;
			if (fail_running) begin
				e.lit = blink_on;
				r = LEVEL_FULL;
			end else begin
				case (mode)
					MODE_PROVISIONING: begin
						e.lit = blink_on;
						b = LEVEL_FULL;
					end
					MODE_BLE: begin
						e.lit = 1'b1;
						b = LEVEL_FULL;
					end
					MODE_CONNECTING: begin
						e.lit = blink_on;
						r = LEVEL_FULL;
						g = LEVEL_AMBER;
					end
					MODE_CONNECTED: begin
						e.lit = 1'b1;
						g = LEVEL_FULL;
					end
					// purple shares the 180 level with amber
					MODE_UPDATING: begin
						e.lit = blink_on;
						r = LEVEL_AMBER;
						b = LEVEL_FULL;
					end
					// lit even when the custom colour is black
					MODE_CUSTOM: begin
						e.lit = 1'b1;
						{r, g, b} = custom;
					end
					default: ;
				endcase
			end
			if (!e.lit)
				{r, g, b} = '0;
			e.red_out   = scaled(r);
			e.green_out = scaled(g);
			e.blue_out  = scaled(b);
			e.failing   = fail_running;
			display_q.push_back(e);
		endfunction

		function void flag(input string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%s", what);
		endfunction

		function void check_display(input rsp_item_t got);
			rsp_item_t e;
			if (display_q.size() == 0) begin
				flag($sformatf("unexpected display item: r %0d g %0d b %0d lit %0b failing %0b",
					got.red_out, got.green_out, got.blue_out, got.lit, got.failing));
				return;
			end
			e = display_q.pop_front();
			if (got.red_out !== e.red_out || got.green_out !== e.green_out ||
					got.blue_out !== e.blue_out || got.lit !== e.lit ||
					got.failing !== e.failing)
				flag($sformatf({"display mismatch: expected r %0d g %0d b %0d lit %0b failing %0b,",
					" got r %0d g %0d b %0d lit %0b failing %0b"},
					e.red_out, e.green_out, e.blue_out, e.lit, e.failing,
					got.red_out, got.green_out, got.blue_out, got.lit, got.failing));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_item_t   req;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_item_t   rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	display_checker board = new();
	bit             steady = 1'b0;
	int unsigned    cycles = 0;

	status_led_pattern_controller_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// every handshake is taken from the values seen at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.set_register(cfg_index, cfg_data);
			if (req_valid && req_ready)
				board.note_event(req);
			if (rsp_valid && rsp_ready)
				board.check_display(rsp);
		end
	end

	function automatic req_item_t compose_request(input kind_t kind, input logic [2:0] mode,
			input logic [23:0] colour);
		req_item_t it;
		it.kind = kind;
		it.mode = mode;
		{it.red_in, it.green_in, it.blue_in} = colour;
		return it;
	endfunction

	function automatic req_item_t random_request(input int tick_pct);
		req_item_t it;
		int        pick;
		it = compose_request(KIND_TICK, 3'($urandom_range(7)), 24'($urandom));
		if ($urandom_range(99) >= tick_pct) begin
			pick = $urandom_range(9);
			if (pick < 5)
				it.kind = KIND_MODE;
			else if (pick < 8)
				it.kind = KIND_COLOUR;
			else
				it.kind = KIND_FAIL;
		end
		return it;
	endfunction

	task automatic send_item(input req_item_t it);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// let the clock advance first so the last accepted item is already on the board
	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure_phase(input int ph);
		logic [15:0] bright;
		logic [15:0] slow;
		logic [15:0] fast;
		logic [15:0] fail;
		logic [15:0] count;
		case (ph)
			// zero half-periods and zero flash count act as one
			SETUP_PHASE: begin
				bright = 16'd255;
				slow   = 16'd2;
				fast   = 16'd0;
				fail   = 16'd0;
				count  = 16'd0;
			end
			0: begin
				bright = 16'($urandom);
				slow   = 16'($urandom_range(8, 1));
				fast   = 16'($urandom_range(4, 1));
				fail   = 16'($urandom_range(4, 1));
				count  = 16'($urandom_range(4, 1));
			end
			1: begin
				bright = 16'd0;
				slow   = 16'd1;
				fast   = 16'd1;
				fail   = 16'd1;
				count  = 16'd15;
			end
			// counts past eight bits
			2: begin
				bright = 16'd255;
				slow   = 16'd257;
				fast   = 16'd300;
				fail   = 16'd2;
				count  = 16'd2;
			end
			// longest periods; upper data bits must be dropped
			3: begin
				bright = 16'($urandom) | 16'hff00;
				slow   = 16'hffff;
				fast   = 16'hffff;
				fail   = 16'hffff;
				count  = 16'hfff0;
			end
			default: begin
				bright = 16'($urandom);
				slow   = 16'($urandom_range(6));
				fast   = 16'($urandom_range(4));
				fail   = 16'($urandom_range(4));
				count  = 16'($urandom);
			end
		endcase
		write_reg(REG_BRIGHTNESS, bright);
		write_reg(REG_SLOW_HALF, slow);
		write_reg(REG_FAST_HALF, fast);
		write_reg(REG_FAIL_HALF, fail);
		write_reg(REG_FAIL_FLASHES, count);
		if (ph == 4)
			write_reg(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: default brightness on white, black and every mode code past off
		send_item(compose_request(KIND_COLOUR, MODE_OFF, 24'hffffff));
		send_item(compose_request(KIND_COLOUR, MODE_SPARE, 24'h000000));
		for (int m = MODE_PROVISIONING; m <= MODE_SPARE; m++)
			send_item(compose_request(KIND_MODE, 3'(m), 24'($urandom)));
		wait_idle();

		configure_phase(SETUP_PHASE);
		send_item(compose_request(KIND_MODE, MODE_CONNECTING, 24'h000000));
		send_item(compose_request(KIND_TICK, MODE_OFF, 24'h000000));
		send_item(compose_request(KIND_TICK, MODE_SPARE, 24'hffffff));
		// a mode event restarts the blink in the on phase
		send_item(compose_request(KIND_MODE, MODE_PROVISIONING, 24'hffffff));
		send_item(compose_request(KIND_TICK, MODE_OFF, 24'h000000));
		send_item(compose_request(KIND_TICK, MODE_OFF, 24'h000000));
		// mode and colour during the flashes are stored, a second failure is replayed
		send_item(compose_request(KIND_FAIL, MODE_OFF, 24'h000000));
		send_item(compose_request(KIND_MODE, MODE_BLE, 24'h000000));
		send_item(compose_request(KIND_FAIL, MODE_OFF, 24'h000000));
		send_item(compose_request(KIND_COLOUR, MODE_OFF, 24'h80ff01));
		repeat (4) send_item(compose_request(KIND_TICK, MODE_OFF, 24'h000000));
		send_item(compose_request(KIND_MODE, MODE_UPDATING, 24'h000000));
		send_item(compose_request(KIND_TICK, MODE_OFF, 24'h000000));

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			configure_phase(ph);
			steady = (ph == STEADY_PHASE);
			repeat (PHASE_ITEMS)
				send_item(random_request((ph == 2) ? 97 : 75));
		end

		wait_idle();
		steady = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.flag($sformatf("%0d display items never arrived", board.pending()));
		if (board.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/slpc_pkg.sv
rtl/status_led_pattern_controller_core.sv
sim/testbench.sv
